// File: hw/rtl/gfba_pkg.sv
package gfba_pkg;

  localparam int GROUP_SIZE_DEF = 15;
  localparam int NUM_BLOCKS_DEF = 256;

  // fixed field widths
  localparam int BLK_W  = 8;
  localparam int FREE_W = 9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SPILL,
    ST_RELOAD
  } state_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_IGNORE,
    ACT_PUSH,
    ACT_SPILL,
    ACT_POP,
    ACT_RELOAD,
    ACT_TAKE_LAST,
    ACT_FAIL
  } act_t;

  typedef struct packed {
    logic accept;
    act_t act;
    logic spill_en;
    logic reload_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_free;
    logic blk_ok;
    logic head_full;
    logic head_multi;
    logic any_free;
    logic rec_valid;
    logic out_block;
    logic spill_last;
    logic reload_last;
  } dp_stat_t;

endpackage

// File: hw/rtl/gfba_ram.sv
module gfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/gfba_dp.sv
module gfba_dp #(
  parameter int GROUP_SIZE = gfba_pkg::GROUP_SIZE_DEF,
  parameter int NUM_BLOCKS = gfba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_command,
  input  logic [gfba_pkg::BLK_W-1:0]  in_block_id,
  input  logic                     out_stall,
  input  gfba_pkg::ctrl_cmd_t      cmd,
  output gfba_pkg::dp_stat_t       stat,
  output logic                     out_valid,
  output logic                     out_status,
  output logic [gfba_pkg::BLK_W-1:0]  out_granted_block,
  output logic [gfba_pkg::FREE_W-1:0] out_free_blocks
);

  localparam int BW    = gfba_pkg::BLK_W;
  localparam int CW    = $clog2(GROUP_SIZE + 1);
  localparam int SW    = $clog2(GROUP_SIZE);
  localparam int FW    = $clog2(NUM_BLOCKS + 1);
  localparam int VW    = $clog2(NUM_BLOCKS);
  localparam int DEPTH = NUM_BLOCKS * GROUP_SIZE;
  localparam int AW    = $clog2(DEPTH);

  logic [BW-1:0] stack_r [GROUP_SIZE];
  logic          valid_r [NUM_BLOCKS];

  logic [CW-1:0] count_r, count_nxt;
  logic [FW-1:0] free_r, free_nxt;
  logic [CW-1:0] step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          cmd_r;
  logic [BW-1:0] blk_r;
  logic [AW-1:0] base_r, base_nxt;
  logic          out_status_r, out_status_nxt;
  logic [BW-1:0] out_granted_r, out_granted_nxt;
  logic [FW-1:0] out_free_r;

  logic [SW-1:0] rd_idx;
  logic [BW-1:0] stack_rd;
  logic [BW-1:0] stack0;
  logic          stack_we;
  logic [SW-1:0] stack_widx;
  logic [BW-1:0] stack_wdata;
  logic [AW-1:0] ram_addr;
  logic [BW-1:0] ram_rdata;
  logic          stack0_ok;
  logic          blk_ok;

  assign stack0    = stack_r[0];
  assign rd_idx    = cmd.spill_en ? SW'(step_r) : SW'(count_r - 1'b1);
  assign stack_rd  = stack_r[rd_idx];
  assign stack0_ok = 32'(stack0) < NUM_BLOCKS;
  assign blk_ok    = 32'(blk_r) < NUM_BLOCKS;
  assign ram_addr  = base_r + AW'(step_r);

  always_comb begin
    stat.is_free     = cmd_r;
    stat.blk_ok      = blk_ok;
    stat.head_full   = (32'(count_r) == GROUP_SIZE);
    stat.head_multi  = (count_r > CW'(1));
    stat.any_free    = (free_r != '0);
    stat.rec_valid   = stack0_ok && valid_r[VW'(stack0)];
    stat.out_block   = out_valid_r && out_stall;
    stat.spill_last  = (32'(step_r) == GROUP_SIZE - 1);
    stat.reload_last = (32'(step_r) == GROUP_SIZE);
  end

  // counters and result fields for the decided action
  always_comb begin
    count_nxt       = count_r;
    free_nxt        = free_r;
    base_nxt        = base_r;
    out_status_nxt  = 1'b0;
    out_granted_nxt = '0;
    case (cmd.act)
      gfba_pkg::ACT_PUSH: begin
        count_nxt = count_r + 1'b1;
        if (32'(free_r) < NUM_BLOCKS) free_nxt = free_r + 1'b1;
      end
      gfba_pkg::ACT_SPILL: begin
        count_nxt = CW'(1);
        base_nxt  = AW'(blk_r) * AW'(GROUP_SIZE);
        if (32'(free_r) < NUM_BLOCKS) free_nxt = free_r + 1'b1;
      end
      gfba_pkg::ACT_POP: begin
        count_nxt       = count_r - 1'b1;
        out_granted_nxt = stack_rd;
        if (free_r != '0) free_nxt = free_r - 1'b1;
      end
      gfba_pkg::ACT_RELOAD: begin
        count_nxt       = CW'(GROUP_SIZE);
        base_nxt        = AW'(stack0) * AW'(GROUP_SIZE);
        out_granted_nxt = stack0;
        free_nxt        = free_r - 1'b1;
      end
      gfba_pkg::ACT_TAKE_LAST: begin
        count_nxt       = '0;
        out_granted_nxt = stack0;
        free_nxt        = free_r - 1'b1;
      end
      gfba_pkg::ACT_FAIL: begin
        out_status_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (cmd.act == gfba_pkg::ACT_SPILL || cmd.act == gfba_pkg::ACT_RELOAD) begin
      step_nxt = '0;
    end else if (cmd.spill_en || cmd.reload_en) begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.act != gfba_pkg::ACT_NONE) out_valid_nxt = 1'b1;
  end

  // single write port of the head stack
  always_comb begin
    stack_we    = 1'b0;
    stack_widx  = '0;
    stack_wdata = blk_r;
    if (cmd.act == gfba_pkg::ACT_PUSH) begin
      stack_we   = 1'b1;
      stack_widx = SW'(count_r);
    end else if (cmd.spill_en && stat.spill_last) begin
      stack_we   = 1'b1;
    end else if (cmd.reload_en && step_r != '0) begin
      // read data is registered, so it belongs to the address issued on the previous step
      stack_we    = 1'b1;
      stack_widx  = SW'(step_r - 1'b1);
      stack_wdata = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      free_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      valid_r     <= '{default: 1'b0};
    end else begin
      count_r     <= count_nxt;
      free_r      <= free_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.act == gfba_pkg::ACT_SPILL) begin
        valid_r[VW'(blk_r)] <= 1'b1;
      end else if (cmd.act == gfba_pkg::ACT_RELOAD) begin
        valid_r[VW'(stack0)] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r <= in_command;
      blk_r <= in_block_id;
    end
    base_r <= base_nxt;
    if (cmd.act != gfba_pkg::ACT_NONE) begin
      out_status_r  <= out_status_nxt;
      out_granted_r <= out_granted_nxt;
      out_free_r    <= free_nxt;
    end
    if (stack_we) begin
      stack_r[stack_widx] <= stack_wdata;
    end
  end

  gfba_ram #(
    .WIDTH(BW),
    .DEPTH(DEPTH)
  ) u_records (
    .clk  (clk),
    .we   (cmd.spill_en),
    .waddr(ram_addr),
    .wdata(stack_rd),
    .raddr(ram_addr),
    .rdata(ram_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_block = out_granted_r;
  assign out_free_blocks   = gfba_pkg::FREE_W'(out_free_r);

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= GROUP_SIZE)
    else $error("head count beyond group size");

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(free_r) <= NUM_BLOCKS)
    else $error("free total beyond block count");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_granted_r == '0))
    else $error("failed allocate carries a block number");

  a_reload_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.act == gfba_pkg::ACT_RELOAD) |=> (32'(count_r) == GROUP_SIZE))
    else $error("reload did not fill the head stack");

endmodule

// File: hw/rtl/gfba_ctrl.sv
module gfba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gfba_pkg::dp_stat_t  stat,
  output gfba_pkg::ctrl_cmd_t cmd
);

  gfba_pkg::state_t state_r, state_nxt;
  gfba_pkg::act_t   act;

  // action for the held request, taken once the result slot is free
  always_comb begin
    act = gfba_pkg::ACT_NONE;
    if (state_r == gfba_pkg::ST_DECIDE && !stat.out_block) begin
      if (stat.is_free) begin
        if (!stat.blk_ok)        act = gfba_pkg::ACT_IGNORE;
        else if (stat.head_full) act = gfba_pkg::ACT_SPILL;
        else                     act = gfba_pkg::ACT_PUSH;
      end else if (stat.head_multi) begin
        act = gfba_pkg::ACT_POP;
      end else if (stat.any_free) begin
        act = stat.rec_valid ? gfba_pkg::ACT_RELOAD : gfba_pkg::ACT_TAKE_LAST;
      end else begin
        act = gfba_pkg::ACT_FAIL;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gfba_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = gfba_pkg::ST_DECIDE;
      end
      gfba_pkg::ST_DECIDE: begin
        if (act == gfba_pkg::ACT_SPILL)       state_nxt = gfba_pkg::ST_SPILL;
        else if (act == gfba_pkg::ACT_RELOAD) state_nxt = gfba_pkg::ST_RELOAD;
        else if (act != gfba_pkg::ACT_NONE)   state_nxt = gfba_pkg::ST_IDLE;
      end
      gfba_pkg::ST_SPILL: begin
        if (stat.spill_last) state_nxt = gfba_pkg::ST_IDLE;
      end
      gfba_pkg::ST_RELOAD: begin
        if (stat.reload_last) state_nxt = gfba_pkg::ST_IDLE;
      end
      default: state_nxt = gfba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state_r != gfba_pkg::ST_IDLE);
    cmd.accept    = (state_r == gfba_pkg::ST_IDLE) && in_valid;
    cmd.act       = act;
    cmd.spill_en  = (state_r == gfba_pkg::ST_SPILL);
    cmd.reload_en = (state_r == gfba_pkg::ST_RELOAD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gfba_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/grouped_free_block_allocator.sv
// flow: a request is registered on its input transfer and decided in the decide state, and
//   the result is registered; the decision waits while a pending result stays stalled
// requests: a new request is taken only in the idle state; a free into a full head stack
//   also spills it (through the record memory write port), and an
//   allocate that reloads reads its record back (registered record memory read)
// reset: synchronous active low; clears counts, record valid bits and handshake
module grouped_free_block_allocator #(
  parameter int GROUP_SIZE = gfba_pkg::GROUP_SIZE_DEF,
  parameter int NUM_BLOCKS = gfba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_command,
  input  logic [gfba_pkg::BLK_W-1:0]  in_block_id,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_status,
  output logic [gfba_pkg::BLK_W-1:0]  out_granted_block,
  output logic [gfba_pkg::FREE_W-1:0] out_free_blocks
);

  gfba_pkg::ctrl_cmd_t cmd;
  gfba_pkg::dp_stat_t  stat;

  gfba_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  gfba_dp #(
    .GROUP_SIZE(GROUP_SIZE),
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_command),
    .in_block_id      (in_block_id),
    .out_stall        (out_stall),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_granted_block(out_granted_block),
    .out_free_blocks  (out_free_blocks)
  );

endmodule

// File: dv/free_list_checker.sv
package gfba_tb_pkg;

  localparam logic CMD_ALLOC        = 1'b0;
  localparam logic CMD_FREE         = 1'b1;
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NONE_FREE = 1'b1;

endpackage

module free_list_checker #(
  parameter int GROUP_SIZE = gfba_pkg::GROUP_SIZE_DEF,
  parameter int NUM_BLOCKS = gfba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_command,
  input  logic [gfba_pkg::BLK_W-1:0]  in_block_id,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_status,
  input  logic [gfba_pkg::BLK_W-1:0]  out_granted_block,
  input  logic [gfba_pkg::FREE_W-1:0] out_free_blocks,
  output int                          mismatches,
  output int                          outstanding,
  output int                          spills,
  output int                          reloads
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_LIMIT = 20;

  typedef struct packed {
    logic                        status;
    logic [gfba_pkg::BLK_W-1:0]  block;
    logic [gfba_pkg::FREE_W-1:0] free_left;
  } grant_t;

  grant_t                     expected_grants[$];
  logic [gfba_pkg::BLK_W-1:0] head_entries [GROUP_SIZE];
  logic [gfba_pkg::BLK_W-1:0] group_rec [NUM_BLOCKS][GROUP_SIZE];
  bit                         rec_loaded [NUM_BLOCKS];
  int                         head_depth;
  int                         free_count;

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  function automatic grant_t serve_request(input logic cmd,
                                           input logic [gfba_pkg::BLK_W-1:0] blk);
    grant_t r;
    r.status = gfba_tb_pkg::STATUS_OK;
    r.block  = '0;
    if (cmd == gfba_tb_pkg::CMD_FREE) begin
      if (int'(blk) < NUM_BLOCKS) begin
        if (head_depth < GROUP_SIZE) begin
          head_entries[head_depth] = blk;
          head_depth++;
        end else begin
          // full head moves into the freed block's record
          for (int i = 0; i < GROUP_SIZE; i++) group_rec[blk][i] = head_entries[i];
          rec_loaded[blk] = 1'b1;
          head_entries[0] = blk;
          head_depth = 1;
          spills++;
        end
        if (free_count < NUM_BLOCKS) free_count++;
      end
    end else if (head_depth > 1) begin
      head_depth--;
      r.block = head_entries[head_depth];
      if (free_count > 0) free_count--;
    end else if (free_count >= 1) begin
      // last entry goes out, head refills from its record if one was spilled
      r.block = head_entries[0];
      if (int'(r.block) < NUM_BLOCKS && rec_loaded[r.block]) begin
        for (int i = 0; i < GROUP_SIZE; i++) head_entries[i] = group_rec[r.block][i];
        head_depth = GROUP_SIZE;
        rec_loaded[r.block] = 1'b0;
        reloads++;
      end else begin
        head_depth = 0;
      end
      free_count--;
    end else begin
      r.status = gfba_tb_pkg::STATUS_NONE_FREE;
    end
    r.free_left = free_count[gfba_pkg::FREE_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    grant_t want;
    if (!rst_n) begin
      expected_grants.delete();
      head_depth = 0;
      free_count = 0;
      mismatches = 0;
      spills     = 0;
      reloads    = 0;
      foreach (head_entries[i]) head_entries[i] = '0;
      foreach (rec_loaded[i]) rec_loaded[i] = 1'b0;
      outstanding <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_grants.size() == 0) begin
          report_mismatch($sformatf(
              "result transfer with none pending: status %0d block %0d free %0d",
              out_status, out_granted_block, out_free_blocks));
        end else begin
          want = expected_grants.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_granted_block !== want.block)
            report_mismatch($sformatf("granted_block %0d, want %0d",
                                      out_granted_block, want.block));
          if (out_free_blocks !== want.free_left)
            report_mismatch($sformatf("free_blocks %0d, want %0d",
                                      out_free_blocks, want.free_left));
        end
      end
      if (in_valid && !in_stall) begin
        expected_grants.push_back(serve_request(in_command, in_block_id));
      end
      outstanding <= expected_grants.size();
    end
  end

endmodule

// File: dv/tb_grouped_free_block_allocator.sv
module tb_grouped_free_block_allocator ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GROUP_SIZE  = gfba_pkg::GROUP_SIZE_DEF;
  localparam int NUM_BLOCKS  = gfba_pkg::NUM_BLOCKS_DEF;
  localparam int RANDOM_REQS = 620;
  localparam int QUIET_LIMIT = 2000;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  logic                        clk;
  logic                        rst_n       = 1'b0;
  logic                        in_valid    = 1'b0;
  logic                        in_stall;
  logic                        in_command  = gfba_tb_pkg::CMD_ALLOC;
  logic [gfba_pkg::BLK_W-1:0]  in_block_id = '0;
  logic                        out_valid;
  logic                        out_stall   = 1'b0;
  logic                        out_status;
  logic [gfba_pkg::BLK_W-1:0]  out_granted_block;
  logic [gfba_pkg::FREE_W-1:0] out_free_blocks;
  logic                        calm        = 1'b0;

  int mismatches;
  int outstanding;
  int spills;
  int reloads;

  // blocks the requester holds; only these may be freed
  logic [gfba_pkg::BLK_W-1:0] owned_blocks[$];
  logic                       issued_cmds[$];
  int frees_sent;
  int allocs_sent;
  int refused_allocs;
  int quiet_cycles;

  grouped_free_block_allocator u_dut (.*);

  free_list_checker u_check (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(0, 99) < 25);
  end

  // granted blocks come back to the requester, plus the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) issued_cmds.push_back(in_command);
      if (out_valid && !out_stall && issued_cmds.size() != 0) begin
        if (issued_cmds.pop_front() == gfba_tb_pkg::CMD_ALLOC) begin
          if (out_status == gfba_tb_pkg::STATUS_OK) owned_blocks.push_back(out_granted_block);
          else refused_allocs++;
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no transfer for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_request(input logic cmd, input logic [gfba_pkg::BLK_W-1:0] blk);
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_block_id <= blk;
    do @(posedge clk); while (in_stall);
    if (cmd == gfba_tb_pkg::CMD_FREE) frees_sent++;
    else allocs_sent++;
  endtask

  task automatic free_block(input logic [gfba_pkg::BLK_W-1:0] blk);
    foreach (owned_blocks[i]) begin
      if (owned_blocks[i] == blk) begin
        owned_blocks.delete(i);
        break;
      end
    end
    send_request(gfba_tb_pkg::CMD_FREE, blk);
  endtask

  initial begin : stimulus
    phase_t phase;
    int     free_pct;
    phase = PH_FILL;
    for (int b = 0; b < NUM_BLOCKS; b++) owned_blocks.push_back(gfba_pkg::BLK_W'(b));
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(gfba_tb_pkg::CMD_ALLOC, 8'h00);   // nothing free yet
    free_block(8'hff);
    send_request(gfba_tb_pkg::CMD_ALLOC, 8'hff);   // last entry, its record never spilled
    for (int b = 0; b <= GROUP_SIZE; b++) free_block(gfba_pkg::BLK_W'(b));
    send_request(gfba_tb_pkg::CMD_ALLOC, 8'h5a);   // reload from the spilled record
    send_request(gfba_tb_pkg::CMD_ALLOC, 8'ha5);

    // fill every block, drain until refused, then a balanced mix
    for (int n = 0; n < RANDOM_REQS; n++) begin
      calm <= (n >= 200 && n < 300);
      if (phase == PH_FILL && owned_blocks.size() == 0) phase = PH_DRAIN;
      else if (phase == PH_DRAIN && refused_allocs >= 4) phase = PH_MIXED;
      free_pct = (phase == PH_FILL) ? 97 : (phase == PH_DRAIN) ? 5 : 50;
      if (owned_blocks.size() != 0 && $urandom_range(0, 99) < free_pct)
        free_block(owned_blocks[$urandom_range(0, owned_blocks.size() - 1)]);
      else
        send_request(gfba_tb_pkg::CMD_ALLOC, gfba_pkg::BLK_W'($urandom));
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (2 * GROUP_SIZE + 8) @(posedge clk);

    $display("requests: %0d frees, %0d allocates, %0d refused for lack of free blocks",
             frees_sent, allocs_sent, refused_allocs);
    $display("group spills %0d, group reloads %0d", spills, reloads);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: grouped_free_block_allocator.f
hw/rtl/gfba_pkg.sv
hw/rtl/gfba_ram.sv
hw/rtl/gfba_dp.sv
hw/rtl/gfba_ctrl.sv
hw/rtl/grouped_free_block_allocator.sv
dv/free_list_checker.sv
dv/tb_grouped_free_block_allocator.sv
